FILE: design/assert_macros.svh
// assertion macros shared by the odometry rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DDO_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/ddo_pkg.sv
// types, constants and tables of the differential drive odometry
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FIFO_DEPTH = 2;

  // q1.30 cordic gain start value
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // configuration register indexes
  localparam logic [2:0] REG_DIST_PER_TICK = 3'd0;
  localparam logic [2:0] REG_HEAD_PER_DIFF = 3'd1;
  localparam logic [2:0] REG_START_X       = 3'd2;
  localparam logic [2:0] REG_START_Y       = 3'd3;
  localparam logic [2:0] REG_START_HEADING = 3'd4;

  // one classified sample between front and back
  typedef struct packed {
    logic               restart;
    logic signed [32:0] sum;
    logic signed [32:0] diff;
  } ddo_entry_t;

  typedef struct packed {
    logic [31:0] dist_per_tick;
    logic [31:0] head_per_diff;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_heading;
  } ddo_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DIST,
    ST_MUL_HEAD,
    ST_ROTATE,
    ST_PX_LO,
    ST_PX_HI,
    ST_PY_LO,
    ST_PY_HI,
    ST_DONE
  } ddo_state_e;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/ddo_fifo.sv
// two-entry queue between the sample front and the pose back
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ddo_fifo
  import ddo_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire ddo_entry_t wdata_i,
  input  wire logic       pop_i,
  output ddo_entry_t      rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  ddo_entry_t mem_q [FIFO_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(FIFO_DEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `DDO_ASSERT(a_no_overflow, !(push_i && full_o))
  `DDO_ASSERT(a_no_underflow, !(pop_i && empty_o))
  `DDO_ASSERT_NEXT(a_last_pop_empties, cnt_q == 2'd1 && pop_i && !push_i, empty_o)

endmodule
`default_nettype wire

FILE: design/ddo_front.sv
// sample front: keeps last counts and forms tick sum and difference
`timescale 1ns / 1ps
`default_nettype none
module ddo_front
  import ddo_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] left_count_i,
  input  wire logic [31:0] right_count_i,
  input  wire logic        restart_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output ddo_entry_t       q_wdata_o
);

  logic [31:0]        last_left_q, last_right_q;
  logic signed [31:0] dl, dr;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // signed deltas modulo 2^32
  always_comb begin
    dl = $signed(left_count_i - last_left_q);
    dr = $signed(right_count_i - last_right_q);
    q_wdata_o.restart = restart_i;
    q_wdata_o.sum     = 33'(dl) + 33'(dr);
    q_wdata_o.diff    = 33'(dr) - 33'(dl);
  end

  // reference counts follow every beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_left_q  <= '0;
      last_right_q <= '0;
    end else if (q_push_o) begin
      last_left_q  <= left_count_i;
      last_right_q <= right_count_i;
    end
  end

endmodule
`default_nettype wire

FILE: design/ddo_back.sv
// pose back: scaling, cordic rotation and saturating position update
`timescale 1ns / 1ps
`default_nettype none
module ddo_back
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ddo_cfg_t   cfg_i,
  input  wire logic       q_empty_i,
  input  wire ddo_entry_t q_rdata_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [95:0]     out_data_o
);

  ddo_state_e state_q, state_d;

  ddo_entry_t         ent_q;
  logic [46:0]        dmag_q;
  logic               dneg_q;
  logic [31:0]        dfi_q;
  logic               flip_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic [4:0]         iter_q;
  logic [34:0]        acc_q;
  logic [31:0]        px_q, py_q;
  logic [31:0]        pose_x_q, pose_y_q, pose_h_q;
  logic [95:0]        odata_q;
  logic               ovalid_q;

  logic               out_free;
  logic               last_iter;
  logic [32:0]        sum_abs;
  logic [64:0]        dprod;
  logic signed [32:0] hpt_s;
  logic signed [65:0] hprod;
  logic [31:0]        mid, angle;
  logic               mid_flip;
  logic signed [33:0] xs, ys, at;
  logic signed [33:0] c_sel, c_val;
  logic               c_neg;
  logic [33:0]        c_abs;
  logic [31:0]        m_a;
  logic [65:0]        mul;
  logic [49:0]        r;
  logic signed [50:0] sv;
  logic [31:0]        p_sel;
  logic signed [51:0] sumv;
  logic [31:0]        sat;

  assign out_free    = !ovalid_q || out_ready_i;
  assign last_iter   = (iter_q == 5'(CORDIC_STEPS - 1));
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (!q_empty_i) state_d = q_rdata_i.restart ? ST_DONE : ST_MUL_DIST;
      ST_MUL_DIST: state_d = ST_MUL_HEAD;
      ST_MUL_HEAD: state_d = ST_ROTATE;
      ST_ROTATE:   if (last_iter) state_d = ST_PX_LO;
      ST_PX_LO:    state_d = ST_PX_HI;
      ST_PX_HI:    state_d = ST_PY_LO;
      ST_PY_LO:    state_d = ST_PY_HI;
      ST_PY_HI:    state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: q_pop_o = !q_empty_i;
      default: q_pop_o = 1'b0;
    endcase
  end

  // distance and heading products
  always_comb begin
    sum_abs  = ent_q.sum[32] ? 33'(-ent_q.sum) : 33'(ent_q.sum);
    dprod    = 65'(sum_abs) * 65'(cfg_i.dist_per_tick);
    hpt_s    = $signed({1'b0, cfg_i.head_per_diff});
    hprod    = ent_q.diff * hpt_s;
    mid      = pose_h_q + hprod[48:17];
    mid_flip = mid[31] ^ mid[30];
    angle    = mid_flip ? {~mid[31], mid[30:0]} : mid;
  end

  // one cordic micro-rotation
  always_comb begin
    xs = x_q >>> iter_q;
    ys = y_q >>> iter_q;
    at = $signed({2'b00, atan_turn(iter_q)});
  end

  // shared partial-product multiplier for d times cos or sin
  always_comb begin
    c_sel = (state_q == ST_PX_LO || state_q == ST_PX_HI) ? x_q : y_q;
    c_val = flip_q ? -c_sel : c_sel;
    c_neg = c_val[33];
    c_abs = c_neg ? 34'(-c_val) : 34'(c_val);
    m_a   = (state_q == ST_PX_LO || state_q == ST_PY_LO) ? dmag_q[31:0]
                                                         : {17'd0, dmag_q[46:32]};
    mul   = 66'(m_a) * 66'(c_abs);
    r     = 50'({mul[47:0], 2'b00}) + 50'(acc_q);
    sv    = (dneg_q ^ c_neg) ? -$signed({1'b0, r}) : $signed({1'b0, r});
    p_sel = (state_q == ST_PX_HI) ? pose_x_q : pose_y_q;
    sumv  = 52'($signed(p_sel)) + 52'(sv);
    if (sumv > 52'sd2147483647) begin
      sat = 32'h7FFFFFFF;
    end else if (sumv < -52'sd2147483648) begin
      sat = 32'h80000000;
    end else begin
      sat = sumv[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      pose_x_q <= '0;
      pose_y_q <= '0;
      pose_h_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (state_q == ST_DONE && out_free) begin
        if (ent_q.restart) begin
          pose_x_q <= cfg_i.start_x;
          pose_y_q <= cfg_i.start_y;
          pose_h_q <= cfg_i.start_heading;
        end else begin
          pose_x_q <= px_q;
          pose_y_q <= py_q;
          pose_h_q <= pose_h_q + dfi_q;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        ent_q <= q_rdata_i;
      end
      ST_MUL_DIST: begin
        dmag_q <= dprod[63:17];
        dneg_q <= ent_q.sum[32];
      end
      ST_MUL_HEAD: begin
        dfi_q  <= hprod[47:16];
        flip_q <= mid_flip;
        z_q    <= $signed({{2{angle[31]}}, angle});
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        iter_q <= '0;
      end
      ST_ROTATE: begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
        iter_q <= iter_q + 5'd1;
      end
      ST_PX_LO, ST_PY_LO: begin
        acc_q <= mul[64:30];
      end
      ST_PX_HI: begin
        px_q <= sat;
      end
      ST_PY_HI: begin
        py_q <= sat;
      end
      default: begin
      end
    endcase
    if (state_q == ST_DONE && out_free) begin
      if (ent_q.restart) begin
        odata_q <= {cfg_i.start_heading, cfg_i.start_y, cfg_i.start_x};
      end else begin
        odata_q <= {pose_h_q + dfi_q, py_q, px_q};
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/diff_drive_odometry.sv
// top level of the differential drive odometry
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata left,right; tuser restart
//  m_axis    out  tvalid/tready          tdata pos_x,pos_y,heading
//  cfg       in   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// a motion sample passes the back sequencer through the distance and heading
// products, the one-step-per-cycle cordic loop of CORDIC_STEPS steps and a
// shared multiplier used four times; a restart sample goes from idle to done.
// reset clears pose and reference counts and loads register defaults.
// a two-entry queue lets the front take samples while the back works;
// the output register holds a result while the sink stalls.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // left_count, right_count
  input  wire logic        s_axis_tuser,  // restart
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // pos_x, pos_y, heading
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  ddo_cfg_t   cfg_q;
  ddo_entry_t q_wdata, q_rdata;
  logic       q_push, q_pop, q_full, q_empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dist_per_tick <= 32'd65536;
      cfg_q.head_per_diff <= 32'd65536;
      cfg_q.start_x       <= '0;
      cfg_q.start_y       <= '0;
      cfg_q.start_heading <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIST_PER_TICK: cfg_q.dist_per_tick <= cfg_wdata_i;
        REG_HEAD_PER_DIFF: cfg_q.head_per_diff <= cfg_wdata_i;
        REG_START_X:       cfg_q.start_x       <= cfg_wdata_i;
        REG_START_Y:       cfg_q.start_y       <= cfg_wdata_i;
        REG_START_HEADING: cfg_q.start_heading <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ddo_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .left_count_i  (s_axis_tdata[31:0]),
    .right_count_i (s_axis_tdata[63:32]),
    .restart_i     (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_wdata_o     (q_wdata)
  );

  ddo_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ddo_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_rdata_i   (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

FILE: test/testbench.sv
// self-checking testbench for the differential drive odometry
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import ddo_pkg::*;

  localparam int NUM_RANDOM = 1400;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [2:0] REG_NONE = 3'd7;  // index with no register behind it

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  // one row of the directed table: a sample or a register write
  typedef struct {
    row_kind_e   kind;
    logic [31:0] a;        // left count or register index
    logic [31:0] b;        // right count or register value
    logic        restart;
    logic        typed;    // expected pose given in the row
    logic [31:0] ex, ey, eh;
  } row_t;

  typedef struct {
    logic [31:0] x, y, h;
  } pose_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // left_count, right_count
  logic        s_axis_tuser = 1'b0;  // restart
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;  // pos_x, pos_y, heading
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  diff_drive_odometry dut (.*);

  // predictor state and configuration
  logic [31:0] dist_per_tick, head_per_diff, start_x, start_y, start_head;
  logic [31:0] ref_left, ref_right, cur_x, cur_y, cur_head;
  logic [31:0] angle_step [32];
  pose_t       pending_poses [$];

  longint cycles = 0;
  int     errors = 0;
  int     beats_in = 0, results_out = 0, restarts = 0;
  int     idle_pct = 0, stall_pct = 0;
  logic   hold_req = 1'b0;
  logic [31:0] drive_left = '0, drive_right = '0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // arctangent of 2^-i, fractions of a turn scaled by 2^32
  initial begin
    angle_step = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                   32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                   32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                   32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                   32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                   32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                   32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                   32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
  end

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // distance times q1.30 factor, shifted by 30 toward zero
  function automatic longint scale_q30(longint d, longint c);
    logic [127:0] p;
    logic [63:0]  ad, ac;
    logic         neg;
    neg = (d < 0) ^ (c < 0);
    ad = (d < 0) ? -d : d;
    ac = (c < 0) ? -c : c;
    p = {64'd0, ad} * {64'd0, ac};
    p = p >> 30;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // rotation mode cordic on a binary angle, cos and sin in q1.30
  task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, nx;
    logic   flip;
    x = 652032874;
    y = 0;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang - 32'h80000000;
    z = longint'(signed'(ang));
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(angle_step[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(angle_step[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // advance the dead-reckoned pose by one sample
  task automatic odometry_update(input logic [31:0] left, input logic [31:0] right,
                                 input logic restart);
    longint      dl, dr, sum, diff, travel, c, s;
    logic [63:0] mag, prod;
    logic [31:0] dturn, mid;
    pose_t       p;
    if (restart) begin
      cur_x = start_x;
      cur_y = start_y;
      cur_head = start_head;
      restarts++;
    end else begin
      dl = longint'(signed'(left - ref_left));
      dr = longint'(signed'(right - ref_right));
      sum = dl + dr;
      diff = dr - dl;
      mag = (sum < 0) ? -sum : sum;
      mag = (mag * {32'd0, dist_per_tick}) >> 17;
      travel = (sum < 0) ? -longint'(mag) : longint'(mag);
      prod = 64'(diff) * {32'd0, head_per_diff};
      dturn = prod[47:16];
      mid = cur_head + prod[48:17];
      rotate_unit(mid, c, s);
      cur_x = clamp32(longint'(signed'(cur_x)) + scale_q30(travel, c));
      cur_y = clamp32(longint'(signed'(cur_y)) + scale_q30(travel, s));
      cur_head = cur_head + dturn;
    end
    ref_left = left;
    ref_right = right;
    p.x = cur_x;
    p.y = cur_y;
    p.h = cur_head;
    pending_poses.push_back(p);
  endtask

  // register write, only while nothing is in flight
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    case (idx)
      REG_DIST_PER_TICK: dist_per_tick = val;
      REG_HEAD_PER_DIFF: head_per_diff = val;
      REG_START_X:       start_x = val;
      REG_START_Y:       start_y = val;
      REG_START_HEADING: start_head = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // offer one beat and wait for it to be taken
  task automatic send_sample(input logic [31:0] left, input logic [31:0] right,
                             input logic restart);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {right, left};
    s_axis_tuser = restart;
    do @(posedge clk_i); while (!s_axis_tready);
    odometry_update(left, right, restart);
    beats_in++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // result sink with random stalls and an optional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare each result beat with the oldest predicted pose
  always @(posedge clk_i) begin
    pose_t p;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_out++;
      if (pending_poses.size() == 0) begin
        errors++;
        $error("result beat with no pose expected: %h", m_axis_tdata);
      end else begin
        p = pending_poses.pop_front();
        if (m_axis_tdata[31:0] !== p.x) begin
          errors++;
          $error("pos_x expected %h actual %h", p.x, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[63:32] !== p.y) begin
          errors++;
          $error("pos_y expected %h actual %h", p.y, m_axis_tdata[63:32]);
        end
        if (m_axis_tdata[95:64] !== p.h) begin
          errors++;
          $error("heading expected %h actual %h", p.h, m_axis_tdata[95:64]);
        end
      end
    end
  end

  function automatic row_t beat_row(logic [31:0] l, logic [31:0] r, logic rs);
    row_t t;
    t = '{ROW_BEAT, l, r, rs, 1'b0, '0, '0, '0};
    return t;
  endfunction

  function automatic row_t typed_row(logic [31:0] l, logic [31:0] r, logic rs,
                                     logic [31:0] x, logic [31:0] y, logic [31:0] h);
    row_t t;
    t = '{ROW_BEAT, l, r, rs, 1'b1, x, y, h};
    return t;
  endfunction

  function automatic row_t cfg_row(logic [2:0] idx, logic [31:0] val);
    row_t t;
    t = '{ROW_CFG, {29'd0, idx}, val, 1'b0, 1'b0, '0, '0, '0};
    return t;
  endfunction

  // one stretch of random samples, mostly smooth motion
  task automatic random_phase(input int count, input logic long_hold);
    int          k;
    logic [31:0] dl, dr;
    for (int n = 0; n < count; n++) begin
      if (long_hold && n == 5) hold_req = 1'b1;
      k = $urandom_range(99);
      if (k < 4) begin
        send_sample($urandom, $urandom, 1'b1);
      end else if (k < 10) begin
        drive_left = $urandom;
        drive_right = $urandom;
        send_sample(drive_left, drive_right, 1'b0);
      end else begin
        dl = $urandom & ((32'd1 << $urandom_range(20)) - 1);
        dr = (k < 40) ? dl : ($urandom & ((32'd1 << $urandom_range(20)) - 1));
        if ($urandom_range(1)) dl = -dl;
        if ($urandom_range(1)) dr = -dr;
        drive_left = drive_left + dl;
        drive_right = drive_right + dr;
        send_sample(drive_left, drive_right, 1'b0);
      end
    end
  endtask

  task automatic random_config(input logic extreme);
    drain();
    if (extreme) begin
      write_reg(REG_DIST_PER_TICK, $urandom_range(1) ? 32'hFFFFFFFF : 32'd1);
      write_reg(REG_HEAD_PER_DIFF, $urandom_range(1) ? 32'hFFFFFFFF : 32'd0);
      write_reg(REG_START_X, $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF);
      write_reg(REG_START_Y, $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF);
    end else begin
      write_reg(REG_DIST_PER_TICK, $urandom >> $urandom_range(16));
      write_reg(REG_HEAD_PER_DIFF, $urandom >> $urandom_range(20));
      write_reg(REG_START_X, $urandom);
      write_reg(REG_START_Y, $urandom);
    end
    write_reg(REG_START_HEADING, $urandom);
  endtask

  initial begin
    row_t directed [$];
    dist_per_tick = 32'd65536;
    head_per_diff = 32'd65536;
    start_x = '0;
    start_y = '0;
    start_head = '0;
    ref_left = '0;
    ref_right = '0;
    cur_x = '0;
    cur_y = '0;
    cur_head = '0;

    // after reset: pose and references at zero
    directed.push_back(typed_row(32'd0, 32'd0, 1'b0, '0, '0, '0));
    directed.push_back(beat_row(32'd10, 32'd10, 1'b0));             // straight
    directed.push_back(beat_row(32'd10, 32'd40, 1'b0));             // turn left
    directed.push_back(beat_row(32'hFFFFFFF0, 32'd1040, 1'b0));     // spin, wrap
    directed.push_back(beat_row(32'h7FFFFFF0, 32'h80000410, 1'b0)); // largest deltas
    directed.push_back(typed_row(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '0, '0, '0));
    // extremes of every register, unknown index ignored
    directed.push_back(cfg_row(REG_DIST_PER_TICK, 32'hFFFFFFFF));
    directed.push_back(cfg_row(REG_HEAD_PER_DIFF, 32'hFFFFFFFF));
    directed.push_back(cfg_row(REG_START_X, 32'h80000000));
    directed.push_back(cfg_row(REG_START_Y, 32'h7FFFFFFF));
    directed.push_back(cfg_row(REG_START_HEADING, 32'hC0000000));
    directed.push_back(cfg_row(REG_NONE, 32'h12345678));
    directed.push_back(typed_row(32'd0, 32'd0, 1'b1, 32'h80000000, 32'h7FFFFFFF,
                                 32'hC0000000));
    directed.push_back(beat_row(32'h80000000, 32'h80000000, 1'b0)); // saturate
    directed.push_back(beat_row(32'h00000000, 32'h00000000, 1'b0));
    directed.push_back(beat_row(32'h00000005, 32'hFFFFFFF0, 1'b0));
    // zero travel per tick: heading still turns
    directed.push_back(cfg_row(REG_DIST_PER_TICK, 32'd0));
    directed.push_back(cfg_row(REG_HEAD_PER_DIFF, 32'd0));
    directed.push_back(beat_row(32'h40000000, 32'h12345678, 1'b0));
    directed.push_back(cfg_row(REG_HEAD_PER_DIFF, 32'h00010000));
    directed.push_back(beat_row(32'h40000100, 32'h12345600, 1'b0));
    directed.push_back(cfg_row(REG_DIST_PER_TICK, 32'd1));
    directed.push_back(beat_row(32'h3FFFFFFF, 32'h12345601, 1'b0));

    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed[i].a[2:0], directed[i].b);
      end else begin
        send_sample(directed[i].a, directed[i].b, directed[i].restart);
        if (directed[i].typed && (pending_poses[$].x !== directed[i].ex ||
            pending_poses[$].y !== directed[i].ey ||
            pending_poses[$].h !== directed[i].eh)) begin
          errors++;
          $error("directed row %0d: predicted pose differs from the table", i);
        end
      end
    end
    drive_left = directed[directed.size() - 1].a;
    drive_right = directed[directed.size() - 1].b;

    // random part over the idling phases
    random_config(1'b0);
    idle_pct = 0;
    stall_pct = 0;
    random_phase(NUM_RANDOM / 4, 1'b1);
    random_config(1'b1);
    idle_pct = 80;
    stall_pct = 0;
    random_phase(NUM_RANDOM / 4, 1'b0);
    random_config(1'b0);
    idle_pct = 0;
    stall_pct = 80;
    random_phase(NUM_RANDOM / 4, 1'b0);
    random_config(1'b0);
    idle_pct = 30;
    stall_pct = 30;
    random_phase(NUM_RANDOM / 4, 1'b0);

    drain();
    $display("covered %0d samples (%0d restarts), %0d poses checked", beats_in,
             restarts, results_out);
    $display("register extremes, zero travel, saturation and a long output hold-off");
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
+incdir+design
design/ddo_pkg.sv
design/ddo_fifo.sv
design/ddo_front.sv
design/ddo_back.sv
design/diff_drive_odometry.sv
test/testbench.sv
